FILE: hdl/itrl_pkg.sv
// Shared types and constants of the bus-target register bank with log window.
`default_nettype none
package itrl_pkg;

    // Both depths are powers of two: pointers wrap by dropping carry bits.
    localparam int REG_DEPTH = 256;
    localparam int LOG_DEPTH = 256;
    localparam int REG_AW    = $clog2(REG_DEPTH);
    localparam int LOG_AW    = $clog2(LOG_DEPTH);
    localparam int CNT_W     = LOG_AW + 1;

    localparam int BYTE_W    = 8;
    localparam int OP_W      = 3;
    localparam int FILL_W    = 9;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [BYTE_W-1:0] DRAINED_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] WIN_RESET    = 8'hFF;

    typedef enum logic [OP_W-1:0] {
        OP_BUS_WR   = 3'd0,
        OP_BUS_RD   = 3'd1,
        OP_BUS_STOP = 3'd2,
        OP_LOG_APP  = 3'd3,
        OP_LOCAL_WR = 3'd4,
        OP_LOCAL_RD = 3'd5
    } t_op;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture the transaction and read the memories
        logic commit;   // execute it, update state and load the result
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free; // the result register can take a new result
    } t_dp_sts;

endpackage
`default_nettype wire

FILE: hdl/itrl_ctrl.sv
// Controller state machine: sequences load and commit of each transaction.
`default_nettype none
module itrl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire itrl_pkg::t_dp_sts i_sts,
    output itrl_pkg::t_dp_cmd      o_cmd
);
    import itrl_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    logic   r_s_tready;

    always_comb begin
        o_cmd.load   = i_s_tvalid && r_s_tready;
        o_cmd.commit = (r_state == ST_EXEC) && i_sts.out_free;
    end

    assign o_s_tready = r_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_s_tready <= 1'b1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd.load) begin
                        r_state    <= ST_EXEC;
                        r_s_tready <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    if (o_cmd.commit) begin
                        r_state    <= ST_IDLE;
                        r_s_tready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_s_tready <= 1'b1;
                end
            endcase
        end
    end

    a_ready_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_tready == (r_state == ST_IDLE))
        else $error("tready disagrees with controller state");

    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_EXEC))
        else $error("accepted transaction did not enter execution");

    a_commit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == ST_IDLE) && r_s_tready)
        else $error("committed transaction did not release the input");

endmodule
`default_nettype wire

FILE: hdl/itrl_dp.sv
// Datapath: register store, log ring, pointers and the result register.
`default_nettype none
module itrl_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire itrl_pkg::t_dp_cmd             i_cmd,
    output itrl_pkg::t_dp_sts                  o_sts,
    input  wire logic [itrl_pkg::OP_W-1:0]     i_op,
    input  wire logic [itrl_pkg::BYTE_W-1:0]   i_data,
    input  wire logic [itrl_pkg::BYTE_W-1:0]   i_laddr,
    input  wire logic [itrl_pkg::BYTE_W-1:0]   i_win_addr,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic [itrl_pkg::BYTE_W-1:0]        o_read_data,
    output logic [itrl_pkg::FILL_W-1:0]        o_log_fill
);
    import itrl_pkg::*;

    // Memories (no reset); register store entries carry valid bits.
    logic [BYTE_W-1:0] reg_mem [REG_DEPTH];
    logic [BYTE_W-1:0] log_mem [LOG_DEPTH];
    logic [REG_DEPTH-1:0] r_reg_vld;

    // Captured transaction and registered memory reads.
    t_op               r_op;
    logic [BYTE_W-1:0] r_data;
    logic [REG_AW-1:0] r_laddr;
    logic [BYTE_W-1:0] r_reg_q;
    logic              r_reg_vld_q;
    logic [BYTE_W-1:0] r_log_q;

    // Architectural state.
    logic [REG_AW-1:0] r_addr_ptr, n_addr_ptr;
    logic              r_addr_loaded, n_addr_loaded;
    logic [LOG_AW-1:0] r_log_head, n_log_head;
    logic [CNT_W-1:0]  r_log_count, n_log_count;
    logic [CNT_W-1:0]  r_drain_pos, n_drain_pos;
    logic              r_log_was_read, n_log_was_read;

    // Result register.
    logic              r_m_tvalid;
    logic [BYTE_W-1:0] r_read_data, n_read_data;
    logic [FILL_W-1:0] r_log_fill;

    // Write ports.
    logic              reg_we;
    logic [REG_AW-1:0] reg_waddr;
    logic              log_we;
    logic [LOG_AW-1:0] log_waddr;

    logic [REG_AW-1:0] reg_raddr;
    logic [LOG_AW-1:0] log_raddr;
    logic [REG_AW-1:0] data_addr;
    logic              win_hit;
    logic              data_hit;
    logic [BYTE_W-1:0] reg_rd_val;

    assign o_sts.out_free = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid     = r_m_tvalid;
    assign o_read_data    = r_read_data;
    assign o_log_fill     = r_log_fill;

    // Read addresses at load time: the pointer is stable until commit.
    assign reg_raddr = (t_op'(i_op) == OP_LOCAL_RD) ? i_laddr[REG_AW-1:0] : r_addr_ptr;
    assign log_raddr = r_log_head + r_drain_pos[LOG_AW-1:0];

    assign data_addr  = r_data[REG_AW-1:0];
    assign win_hit    = (BYTE_W'(r_addr_ptr) == i_win_addr);
    assign data_hit   = (BYTE_W'(data_addr) == i_win_addr);
    assign reg_rd_val = r_reg_vld_q ? r_reg_q : '0;

    always_comb begin
        n_addr_ptr     = r_addr_ptr;
        n_addr_loaded  = r_addr_loaded;
        n_log_head     = r_log_head;
        n_log_count    = r_log_count;
        n_drain_pos    = r_drain_pos;
        n_log_was_read = r_log_was_read;
        n_read_data    = '0;
        reg_we         = 1'b0;
        reg_waddr      = r_addr_ptr;
        log_we         = 1'b0;
        log_waddr      = r_log_head + r_log_count[LOG_AW-1:0];
        case (r_op)
            OP_BUS_WR: begin
                if (!r_addr_loaded) begin
                    n_addr_ptr    = data_addr;
                    n_addr_loaded = 1'b1;
                    if (data_hit) begin
                        n_drain_pos = '0;
                    end
                end else begin
                    reg_we     = 1'b1;
                    n_addr_ptr = r_addr_ptr + 1'b1;
                end
            end
            OP_BUS_RD: begin
                if (win_hit) begin
                    if (r_drain_pos < r_log_count) begin
                        n_read_data = r_log_q;
                        n_drain_pos = r_drain_pos + 1'b1;
                    end else begin
                        n_read_data = DRAINED_BYTE;
                    end
                    n_log_was_read = 1'b1;
                end else begin
                    n_read_data = reg_rd_val;
                    n_addr_ptr  = r_addr_ptr + 1'b1;
                end
            end
            OP_BUS_STOP: begin
                if (r_log_was_read) begin
                    n_log_head     = '0;
                    n_log_count    = '0;
                    n_drain_pos    = '0;
                    n_log_was_read = 1'b0;
                end
                n_addr_loaded = 1'b0;
            end
            OP_LOG_APP: begin
                log_we = 1'b1;
                if (r_log_count[LOG_AW]) begin
                    // Full: overwrite the oldest byte and move the head on.
                    log_waddr  = r_log_head;
                    n_log_head = r_log_head + 1'b1;
                end else begin
                    n_log_count = r_log_count + 1'b1;
                end
            end
            OP_LOCAL_WR: begin
                reg_we    = 1'b1;
                reg_waddr = r_laddr;
            end
            OP_LOCAL_RD: begin
                n_read_data = reg_rd_val;
            end
            default: begin
            end
        endcase
    end

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_reg_q <= reg_mem[reg_raddr];
            r_log_q <= log_mem[log_raddr];
        end
        if (i_cmd.commit && reg_we) begin
            reg_mem[reg_waddr] <= r_data;
        end
        if (i_cmd.commit && log_we) begin
            log_mem[log_waddr] <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld <= '0;
        end else if (i_cmd.commit && reg_we) begin
            r_reg_vld[reg_waddr] <= 1'b1;
        end
    end

    // Captured payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= t_op'(i_op);
            r_data      <= i_data;
            r_laddr     <= i_laddr[REG_AW-1:0];
            r_reg_vld_q <= r_reg_vld[reg_raddr];
        end
        if (i_cmd.commit) begin
            r_read_data <= n_read_data;
            r_log_fill  <= FILL_W'(n_log_count);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_ptr     <= '0;
            r_addr_loaded  <= 1'b0;
            r_log_head     <= '0;
            r_log_count    <= '0;
            r_drain_pos    <= '0;
            r_log_was_read <= 1'b0;
            r_m_tvalid     <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_addr_ptr     <= n_addr_ptr;
                r_addr_loaded  <= n_addr_loaded;
                r_log_head     <= n_log_head;
                r_log_count    <= n_log_count;
                r_drain_pos    <= n_drain_pos;
                r_log_was_read <= n_log_was_read;
                r_m_tvalid     <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_log_count <= CNT_W'(LOG_DEPTH))
        else $error("log count beyond ring depth");

    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain_pos <= r_log_count)
        else $error("drain position beyond log count");

    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_m_tvalid && (r_log_fill == FILL_W'(r_log_count)))
        else $error("result register not loaded on commit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> o_sts.out_free)
        else $error("commit while the result register is still held");

endmodule
`default_nettype wire

FILE: hdl/i2c_target_regbank_with_log_window_top.sv
// Top level of the bus-target register bank with log window.
`default_nettype none
// Each input transaction carries one bus or local event (bus write byte, bus
// read, bus stop, log append, local write, local read) and produces exactly one
// result transaction with the byte read (zero for events that read nothing) and
// the number of bytes held in the 256-entry log ring afterwards. The first bus
// byte after a stop or reset loads the auto-incrementing address pointer; later
// bytes are stored and advance it. A bus read at the address held in the
// log_window_addr register (byte address 0 on the configuration port, reset
// 0xFF) drains the log instead, giving 0xFF once drained, and a stop after such
// a read empties the log. A transaction is first loaded, which reads the
// register store and the log ring through their registered read ports, and
// then executed, which updates the store, the ring and the pointers. The next
// transaction is accepted while the result still waits in
// the output register; execution only stalls when that register is still held
// when the following result is ready. The register store reads as zero until
// written by means of one valid flag per entry, so no clearing pass follows
// reset. The log_window_addr register should be written only while the block
// is idle.
module i2c_target_regbank_with_log_window_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Event stream.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,  // [7:0] data_in, [15:8] local_addr
    input  wire logic [2:0]  i_s_tuser,  // [2:0] op
    // Result stream.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,  // [7:0] read_data, [16:8] log_fill, [23:17] zero
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import itrl_pkg::*;

    localparam int CFG_DW = 32;

    t_dp_cmd           dp_cmd;
    t_dp_sts           dp_sts;
    logic [BYTE_W-1:0] r_win_addr;
    logic [BYTE_W-1:0] read_data;
    logic [FILL_W-1:0] log_fill;
    logic              cfg_wr;

    // Only one register: bit 2 of the byte address selects beyond it.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? '0 : CFG_DW'(r_win_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_addr <= WIN_RESET;
        end else if (cfg_wr) begin
            r_win_addr <= pwdata[BYTE_W-1:0];
        end
    end

    itrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    itrl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_op        (i_s_tuser),
        .i_data      (i_s_tdata[7:0]),
        .i_laddr     (i_s_tdata[15:8]),
        .i_win_addr  (r_win_addr),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_read_data (read_data),
        .o_log_fill  (log_fill)
    );

    assign o_m_tdata = {7'd0, log_fill, read_data};

endmodule
`default_nettype wire
